// ===== src/vtt_pkg.sv =====
`timescale 1ns / 1ps
package vtt_pkg;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned ValueWidth = 32;
  localparam logic [5:0] MaxDistinctReset = 6'd32;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic KindEntry = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [1:0] VerdictEmpty = 2'd0;
  localparam logic [1:0] VerdictTrunc = 2'd1;
  localparam logic [1:0] VerdictStatic = 2'd2;
  localparam logic [1:0] VerdictCand = 2'd3;
endpackage

// ===== src/value_transition_tally_top.sv =====
`timescale 1ns / 1ps
// A sample that changes the value keeps the engine busy for a search of the table, one table
// memory read per cycle, then an update; a first or repeated sample is absorbed in its
// accepting cycle. A finish with n entries runs a selection pass and a stats read per entry,
// then a last pass and the summary. Throughput: one request at a time.
// Reset: rst (synchronous, active high) clears run state, used bits and the limit (to 32).
module value_transition_tally_top #(
  parameter int unsigned TABLE_DEPTH = vtt_pkg::TableDepth,
  parameter int unsigned VALUE_WIDTH = vtt_pkg::ValueWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic signed [31:0] sample_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic signed [31:0] from_value,
  output logic signed [31:0] to_value,
  output logic [31:0] occurrences,
  output logic [31:0] first_index,
  output logic [31:0] last_index,
  output logic [31:0] samples_seen,
  output logic [31:0] changes_seen,
  output logic        truncated,
  output logic [1:0]  verdict,
  output logic        last_result
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_UPDATE, S_SORT, S_EMIT, S_SUMMARY
  } state_t;

  state_t state;
  logic [5:0] max_distinct;

  // Run state
  logic [31:0] prev;
  logic [31:0] sample_cnt;
  logic [31:0] change_cnt;
  logic        dropped;
  logic [CW-1:0] total;
  logic [TABLE_DEPTH-1:0] used;
  logic [TABLE_DEPTH-1:0] emitted;

  // Table memories: (from,to) keys and (count,first,last) stats
  logic [63:0] key_mem [TABLE_DEPTH];
  logic [95:0] stat_mem [TABLE_DEPTH];
  logic [63:0] key_rd;
  logic [95:0] stat_rd;
  logic [IW-1:0] rd_addr;
  logic        key_we;
  logic        stat_we;
  logic [IW-1:0] wr_addr;
  logic [63:0] key_wd;
  logic [95:0] stat_wd;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_wd;
    if (stat_we) stat_mem[wr_addr] <= stat_wd;
    key_rd <= key_mem[rd_addr];
    stat_rd <= stat_mem[rd_addr];
  end

  // Scan control
  logic [CW-1:0] scan;       // address issued
  logic          rd_ok;      // key_rd holds entry rd_idx
  logic [IW-1:0] rd_idx;
  logic [31:0]   cur;        // sample under search
  logic [31:0]   cur_index;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic          best_ok;
  logic [IW-1:0] best_idx;
  logic [63:0]   best_key;

  // Output register
  logic        ov;
  logic        o_kind;
  logic [63:0] o_key;
  logic [95:0] o_stat;
  logic [31:0] o_samples, o_changes;
  logic        o_trunc;
  logic [1:0]  o_verdict;

  logic [31:0] sext;
  logic [CW-1:0] limit;
  logic        match;
  logic        key_lt;

  assign sext = 32'(signed'(sample_value[SW-1:0]));
  assign limit = ({26'd0, max_distinct} > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(max_distinct);
  assign match = used[rd_idx] && key_rd == {prev, cur};
  // signed compare of {from,to}: flip sign bits of each half
  assign key_lt = {~key_rd[63], key_rd[62:32], ~key_rd[31], key_rd[30:0]}
                < {~best_key[63], best_key[62:32], ~best_key[31], best_key[30:0]};

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !ov;
  assign rd_addr = scan[IW-1:0];

  always_comb begin
    key_we = 1'b0;
    stat_we = 1'b0;
    wr_addr = hit ? hit_idx : free_idx;
    key_wd = {prev, cur};
    stat_wd = {32'd1, cur_index, cur_index};
    if (state == S_UPDATE) begin
      if (hit) begin
        stat_we = 1'b1;
        stat_wd = {(stat_rd[95:64] == vtt_pkg::Sat32) ? stat_rd[95:64] : stat_rd[95:64] + 32'd1,
                   stat_rd[63:32], cur_index};
      end else if (free_ok && total < limit) begin
        key_we = 1'b1;
        stat_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_distinct <= vtt_pkg::MaxDistinctReset;
      prev <= '0;
      sample_cnt <= '0;
      change_cnt <= '0;
      dropped <= 1'b0;
      total <= '0;
      used <= '0;
      emitted <= '0;
      ov <= 1'b0;
      scan <= '0;
      rd_ok <= 1'b0;
      hit <= 1'b0;
      free_ok <= 1'b0;
      best_ok <= 1'b0;
    end else begin
      if (ov && out_ready) ov <= 1'b0;
      if (cfg_valid && cfg_ready) max_distinct <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan <= '0;
            rd_ok <= 1'b0;
            hit <= 1'b0;
            free_ok <= 1'b0;
            best_ok <= 1'b0;
            emitted <= '0;
            if (cmd == vtt_pkg::CmdFinish) begin
              state <= S_SORT;
            end else begin
              cur <= sext;
              cur_index <= sample_cnt;
              if (sample_cnt != vtt_pkg::Sat32) sample_cnt <= sample_cnt + 32'd1;
              if (sample_cnt == 32'd0 || sext == prev) begin
                prev <= sext;
              end else begin
                if (change_cnt != vtt_pkg::Sat32) change_cnt <= change_cnt + 32'd1;
                state <= S_SEARCH;
              end
            end
          end
        end
        S_SEARCH: begin
          // one entry per cycle; read data is registered and arrives in the cycle after its address
          if (scan < CW'(TABLE_DEPTH)) scan <= scan + 1'b1;
          rd_ok <= (scan < CW'(TABLE_DEPTH)) && !hit;
          rd_idx <= scan[IW-1:0];
          if (rd_ok && !hit) begin
            if (match) begin
              hit <= 1'b1;
              hit_idx <= rd_idx;
              rd_ok <= 1'b0;
              scan <= CW'(rd_idx);   // re-read stats of the hit entry
            end else if (!used[rd_idx] && !free_ok) begin
              free_ok <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          // done on a hit, or once the last entry has been checked
          if (hit || (!rd_ok && scan == CW'(TABLE_DEPTH)))
            state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!hit) begin
            if (free_ok && total < limit) begin
              used[free_idx] <= 1'b1;
              total <= total + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
          prev <= cur;
          state <= S_IDLE;
        end
        S_SORT: begin
          // find smallest used, not yet emitted key
          if (scan < CW'(TABLE_DEPTH)) scan <= scan + 1'b1;
          rd_ok <= scan < CW'(TABLE_DEPTH);
          rd_idx <= scan[IW-1:0];
          if (rd_ok && used[rd_idx] && !emitted[rd_idx] && (!best_ok || key_lt)) begin
            best_ok <= 1'b1;
            best_idx <= rd_idx;
            best_key <= key_rd;
          end
          if (!rd_ok && scan == CW'(TABLE_DEPTH)) begin
            if (best_ok) begin
              scan <= CW'(best_idx);
              state <= S_EMIT;
            end else begin
              state <= S_SUMMARY;
            end
          end
        end
        S_EMIT: begin
          // stats of best entry are read on the cycle after the address is issued
          if (!ov && rd_ok) begin
            ov <= 1'b1;
            o_kind <= vtt_pkg::KindEntry;
            o_key <= best_key;
            o_stat <= stat_rd;
            emitted[best_idx] <= 1'b1;
            best_ok <= 1'b0;
            scan <= '0;
            rd_ok <= 1'b0;
            state <= S_SORT;
          end else begin
            rd_ok <= 1'b1;
          end
        end
        S_SUMMARY: begin
          if (!ov) begin
            ov <= 1'b1;
            o_kind <= vtt_pkg::KindSummary;
            o_samples <= sample_cnt;
            o_changes <= change_cnt;
            o_trunc <= dropped;
            if (sample_cnt == 32'd0) o_verdict <= vtt_pkg::VerdictEmpty;
            else if (dropped) o_verdict <= vtt_pkg::VerdictTrunc;
            else if (change_cnt == 32'd0) o_verdict <= vtt_pkg::VerdictStatic;
            else o_verdict <= vtt_pkg::VerdictCand;
            prev <= '0;
            sample_cnt <= '0;
            change_cnt <= '0;
            dropped <= 1'b0;
            total <= '0;
            used <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov;
  assign kind = o_kind;
  assign last_result = o_kind;
  assign from_value = (o_kind == vtt_pkg::KindEntry) ? o_key[63:32] : '0;
  assign to_value = (o_kind == vtt_pkg::KindEntry) ? o_key[31:0] : '0;
  assign occurrences = (o_kind == vtt_pkg::KindEntry) ? o_stat[95:64] : '0;
  assign first_index = (o_kind == vtt_pkg::KindEntry) ? o_stat[63:32] : '0;
  assign last_index = (o_kind == vtt_pkg::KindEntry) ? o_stat[31:0] : '0;
  assign samples_seen = (o_kind == vtt_pkg::KindSummary) ? o_samples : '0;
  assign changes_seen = (o_kind == vtt_pkg::KindSummary) ? o_changes : '0;
  assign truncated = (o_kind == vtt_pkg::KindSummary) ? o_trunc : 1'b0;
  assign verdict = (o_kind == vtt_pkg::KindSummary) ? o_verdict : 2'd0;
endmodule

// ===== src/vtt_checker.sv =====
`timescale 1ns / 1ps
module vtt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic       last_result,
  input logic       truncated,
  input logic [1:0] verdict,
  input logic [31:0] samples_seen
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("result dropped while stalled");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_result == kind)
    else $error("last flag does not match summary kind");
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && truncated && samples_seen != 32'd0 |-> verdict == vtt_pkg::VerdictTrunc)
    else $error("truncated run with wrong verdict");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && samples_seen == 32'd0 |-> verdict == vtt_pkg::VerdictEmpty)
    else $error("empty run with wrong verdict");
endmodule

bind value_transition_tally_top vtt_checker u_vtt_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
  .last_result(last_result), .truncated(truncated), .verdict(verdict),
  .samples_seen(samples_seen)
);
